@@ hdl/gdas_pkg.sv @@
`default_nettype none

package gdas_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFF_W    = 16;
   localparam int SERIAL_W = 22;

   // year register carries one extra bit so that MAX_YEAR + 1 is representable
   localparam int YREG_W   = YEAR_W + 1;
   localparam int MAX_YEAR = 9999;

   // x / 100 == (x * REC_100) >> REC_SHIFT for every x below 2**YREG_W
   localparam int REC_100   = 5243;
   localparam int REC_SHIFT = 19;
   localparam int MUL_B_W   = 13;
   localparam int PROD_W    = YREG_W + MUL_B_W;
   localparam int Q_W       = PROD_W - REC_SHIFT;

   // microcode fields
   localparam int PC_W   = 4;
   localparam int OP_W   = 4;
   localparam int MUL_W  = 3;
   localparam int COND_W = 3;

   localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
   localparam logic [OP_W-1:0] OP_Q_LD     = 4'd2;
   localparam logic [OP_W-1:0] OP_LEAP     = 4'd3;
   localparam logic [OP_W-1:0] OP_CLAMPD   = 4'd4;
   localparam logic [OP_W-1:0] OP_SER_Q    = 4'd5;
   localparam logic [OP_W-1:0] OP_SER_ADDP = 4'd6;
   localparam logic [OP_W-1:0] OP_SER_ADDM = 4'd7;
   localparam logic [OP_W-1:0] OP_SET_ADV  = 4'd8;
   localparam logic [OP_W-1:0] OP_ADV_STEP = 4'd9;
   localparam logic [OP_W-1:0] OP_CHK_OV   = 4'd10;
   localparam logic [OP_W-1:0] OP_FINISH   = 4'd11;

   localparam logic [MUL_W-1:0] MUL_NONE  = 3'd0;
   localparam logic [MUL_W-1:0] MUL_Y_REC = 3'd1;
   localparam logic [MUL_W-1:0] MUL_P_REC = 3'd2;
   localparam logic [MUL_W-1:0] MUL_Q_100 = 3'd3;
   localparam logic [MUL_W-1:0] MUL_P_365 = 3'd4;

   localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] C_ADV      = 3'd2;
   localparam logic [COND_W-1:0] C_OFF_ZERO = 3'd3;
   localparam logic [COND_W-1:0] C_NO_ROLL  = 3'd4;
   localparam logic [COND_W-1:0] C_Y_OVER   = 3'd5;

   // program labels
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] PC_LEAP_SUB = 4'd1;
   localparam logic [PC_W-1:0] PC_LOOP     = 4'd11;
   localparam logic [PC_W-1:0] PC_DONE     = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [MUL_W-1:0]  mul;
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
   } ctl_word_type;

   typedef struct packed {
      logic             fire;
      logic [OP_W-1:0]  op;
      logic [MUL_W-1:0] mul;
   } seq_ctl_type;

   typedef struct packed {
      logic adv;
      logic off_zero;
      logic no_roll;
      logic y_over;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ hdl/gdas_if.sv @@
`default_nettype none

interface gdas_req_if;
   logic                           valid;
   logic                           ready;
   logic [gdas_pkg::YEAR_W-1:0]    year;
   logic [gdas_pkg::MONTH_W-1:0]   month;
   logic [gdas_pkg::DAY_W-1:0]     day_of_month;
   logic [gdas_pkg::OFF_W-1:0]     day_offset;

   modport source (output valid, output year, output month, output day_of_month,
                   output day_offset, input ready);
   modport sink (input valid, input year, input month, input day_of_month,
                 input day_offset, output ready);
endinterface

interface gdas_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gdas_pkg::SERIAL_W-1:0]  serial_day;
   logic [gdas_pkg::YEAR_W-1:0]    new_year;
   logic [gdas_pkg::MONTH_W-1:0]   new_month;
   logic [gdas_pkg::DAY_W-1:0]     new_day;
   logic                           year_overflow;

   modport source (output valid, output serial_day, output new_year, output new_month,
                   output new_day, output year_overflow, input ready);
   modport sink (input valid, input serial_day, input new_year, input new_month,
                 input new_day, input year_overflow, output ready);
endinterface

`default_nettype wire

@@ hdl/gdas_sequencer.sv @@
`default_nettype none

module gdas_sequencer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire gdas_pkg::dp_stat_type stat,
   output gdas_pkg::seq_ctl_type      ctl,
   output logic                       req_ready
);

   logic [gdas_pkg::PC_W-1:0] pc_ff, pc_in;
   gdas_pkg::ctl_word_type    word;
   logic                      hold;
   logic                      taken;

   function automatic gdas_pkg::ctl_word_type rom_word(input logic [gdas_pkg::PC_W-1:0] pc);
      gdas_pkg::ctl_word_type w;
      unique case (pc)
         4'd0:  w = '{gdas_pkg::OP_LOAD,     gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         // leap-year subroutine, shared by the start and the year roll
         4'd1:  w = '{gdas_pkg::OP_NOP,      gdas_pkg::MUL_Y_REC, gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd2:  w = '{gdas_pkg::OP_Q_LD,     gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd3:  w = '{gdas_pkg::OP_NOP,      gdas_pkg::MUL_Q_100, gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd4:  w = '{gdas_pkg::OP_LEAP,     gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd5:  w = '{gdas_pkg::OP_CLAMPD,   gdas_pkg::MUL_NONE,  gdas_pkg::C_ADV,
                     gdas_pkg::PC_LOOP};
         // serial day number
         4'd6:  w = '{gdas_pkg::OP_NOP,      gdas_pkg::MUL_P_REC, gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd7:  w = '{gdas_pkg::OP_Q_LD,     gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd8:  w = '{gdas_pkg::OP_SER_Q,    gdas_pkg::MUL_P_365, gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd9:  w = '{gdas_pkg::OP_SER_ADDP, gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         4'd10: w = '{gdas_pkg::OP_SER_ADDM, gdas_pkg::MUL_NONE,  gdas_pkg::C_NEVER,
                     gdas_pkg::PC_IDLE};
         // month-by-month advance
         4'd11: w = '{gdas_pkg::OP_SET_ADV,  gdas_pkg::MUL_NONE,  gdas_pkg::C_OFF_ZERO,
                     gdas_pkg::PC_DONE};
         4'd12: w = '{gdas_pkg::OP_ADV_STEP, gdas_pkg::MUL_NONE,  gdas_pkg::C_NO_ROLL,
                     gdas_pkg::PC_LOOP};
         4'd13: w = '{gdas_pkg::OP_CHK_OV,   gdas_pkg::MUL_NONE,  gdas_pkg::C_Y_OVER,
                     gdas_pkg::PC_DONE};
         4'd14: w = '{gdas_pkg::OP_NOP,      gdas_pkg::MUL_NONE,  gdas_pkg::C_ALWAYS,
                     gdas_pkg::PC_LEAP_SUB};
         4'd15: w = '{gdas_pkg::OP_FINISH,   gdas_pkg::MUL_NONE,  gdas_pkg::C_ALWAYS,
                     gdas_pkg::PC_IDLE};
         default: w = '{gdas_pkg::OP_NOP,    gdas_pkg::MUL_NONE,  gdas_pkg::C_ALWAYS,
                       gdas_pkg::PC_IDLE};
      endcase
      return w;
   endfunction

   assign word = rom_word(pc_ff);

   always_comb begin
      hold = ((word.op == gdas_pkg::OP_LOAD) && !req_valid) ||
             ((word.op == gdas_pkg::OP_FINISH) && !stat.out_free);
      unique case (word.cond)
         gdas_pkg::C_NEVER:    taken = 1'b0;
         gdas_pkg::C_ALWAYS:   taken = 1'b1;
         gdas_pkg::C_ADV:      taken = stat.adv;
         gdas_pkg::C_OFF_ZERO: taken = stat.off_zero;
         gdas_pkg::C_NO_ROLL:  taken = stat.no_roll;
         gdas_pkg::C_Y_OVER:   taken = stat.y_over;
         default:              taken = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + gdas_pkg::PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gdas_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctl.fire  = !hold;
   assign ctl.op    = word.op;
   assign ctl.mul   = word.mul;
   assign req_ready = (word.op == gdas_pkg::OP_LOAD);

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (ctl.fire && word.op == gdas_pkg::OP_FINISH) |=> pc_ff == gdas_pkg::PC_IDLE)
      else $error("sequencer did not return to idle after result");

   a_idle_waits: assert property (@(posedge clock) disable iff (reset)
      (word.op == gdas_pkg::OP_LOAD && !req_valid) |=> pc_ff == gdas_pkg::PC_IDLE)
      else $error("sequencer left idle without a request");

   a_roll_checks_year: assert property (@(posedge clock) disable iff (reset)
      (word.op == gdas_pkg::OP_ADV_STEP && !stat.no_roll) |=>
         word.op == gdas_pkg::OP_CHK_OV)
      else $error("year roll skipped the overflow check");

endmodule

`default_nettype wire

@@ hdl/gdas_datapath.sv @@
`default_nettype none

module gdas_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire gdas_pkg::seq_ctl_type ctl,
   output gdas_pkg::dp_stat_type      stat,
   gdas_req_if.sink                   req_chan,
   gdas_rsp_if.source                 rsp_chan
);

   localparam logic [gdas_pkg::YREG_W-1:0] MAX_Y = gdas_pkg::YREG_W'(gdas_pkg::MAX_YEAR);

   logic [gdas_pkg::YREG_W-1:0]   yr_ff, yr_in;
   logic [gdas_pkg::MONTH_W-1:0]  mo_ff, mo_in;
   logic [gdas_pkg::DAY_W-1:0]    dy_ff, dy_in;
   logic [gdas_pkg::OFF_W-1:0]    off_ff, off_in;
   logic [gdas_pkg::SERIAL_W-1:0] ser_ff, ser_in;
   logic [gdas_pkg::Q_W-1:0]      q_ff, q_in;
   logic [gdas_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic                          leap_ff, leap_in;
   logic                          adv_ff, adv_in;
   logic                          ov_ff, ov_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gdas_pkg::SERIAL_W-1:0] rsp_serial_ff, rsp_serial_in;
   logic [gdas_pkg::YEAR_W-1:0]   rsp_year_ff, rsp_year_in;
   logic [gdas_pkg::MONTH_W-1:0]  rsp_month_ff, rsp_month_in;
   logic [gdas_pkg::DAY_W-1:0]    rsp_day_ff, rsp_day_in;
   logic                          rsp_ov_ff, rsp_ov_in;

   logic [gdas_pkg::YREG_W-1:0]   p;
   logic [gdas_pkg::YREG_W-1:0]   mul_a;
   logic [gdas_pkg::MUL_B_W-1:0]  mul_b;
   logic [gdas_pkg::DAY_W-1:0]    len;
   logic [gdas_pkg::DAY_W-1:0]    left;
   logic                          step_over;
   logic [gdas_pkg::YEAR_W-1:0]   ld_year;
   logic [gdas_pkg::MONTH_W-1:0]  ld_month;
   logic                          fire_finish;

   function automatic logic [gdas_pkg::DAY_W-1:0] month_len(
      input logic [gdas_pkg::MONTH_W-1:0] m, input logic leap);
      logic [gdas_pkg::DAY_W-1:0] r;
      case (m) inside
         4'd2:                   r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default:                r = 5'd31;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] days_before(input logic [gdas_pkg::MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   assign p         = yr_ff - gdas_pkg::YREG_W'(1);
   assign len       = month_len(mo_ff, leap_ff);
   assign left      = len - dy_ff;
   assign step_over = off_ff > gdas_pkg::OFF_W'(left);

   assign ld_year  = (req_chan.year == '0) ? gdas_pkg::YEAR_W'(1) :
                     (gdas_pkg::YREG_W'(req_chan.year) > MAX_Y) ?
                        gdas_pkg::YEAR_W'(gdas_pkg::MAX_YEAR) : req_chan.year;
   assign ld_month = (req_chan.month == '0) ? 4'd1 :
                     (req_chan.month > 4'd12) ? 4'd12 : req_chan.month;

   assign stat.adv      = adv_ff;
   assign stat.off_zero = (off_ff == '0);
   assign stat.no_roll  = !(step_over && mo_ff == 4'd12);
   assign stat.y_over   = yr_ff > MAX_Y;
   assign stat.out_free = !rsp_valid_ff || rsp_chan.ready;

   // shared multiplier, one product per step
   always_comb begin
      case (ctl.mul)
         gdas_pkg::MUL_Y_REC: begin
            mul_a = yr_ff;
            mul_b = gdas_pkg::MUL_B_W'(gdas_pkg::REC_100);
         end
         gdas_pkg::MUL_P_REC: begin
            mul_a = p;
            mul_b = gdas_pkg::MUL_B_W'(gdas_pkg::REC_100);
         end
         gdas_pkg::MUL_Q_100: begin
            mul_a = gdas_pkg::YREG_W'(q_ff);
            mul_b = gdas_pkg::MUL_B_W'(100);
         end
         gdas_pkg::MUL_P_365: begin
            mul_a = p;
            mul_b = gdas_pkg::MUL_B_W'(365);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      if (ctl.mul == gdas_pkg::MUL_NONE) begin
         prod_in = prod_ff;
      end else begin
         prod_in = gdas_pkg::PROD_W'(mul_a) * gdas_pkg::PROD_W'(mul_b);
      end
   end

   always_comb begin
      yr_in   = yr_ff;
      mo_in   = mo_ff;
      dy_in   = dy_ff;
      off_in  = off_ff;
      ser_in  = ser_ff;
      q_in    = q_ff;
      leap_in = leap_ff;
      adv_in  = adv_ff;
      ov_in   = ov_ff;
      fire_finish = 1'b0;
      if (ctl.fire) begin
         unique case (ctl.op)
            gdas_pkg::OP_LOAD: begin
               yr_in  = gdas_pkg::YREG_W'(ld_year);
               mo_in  = ld_month;
               dy_in  = req_chan.day_of_month;
               off_in = req_chan.day_offset;
               adv_in = 1'b0;
               ov_in  = 1'b0;
            end
            gdas_pkg::OP_Q_LD: q_in = prod_ff[gdas_pkg::REC_SHIFT +: gdas_pkg::Q_W];
            gdas_pkg::OP_LEAP: begin
               // divisible by 100 exactly when (y/100)*100 == y
               if (prod_ff == gdas_pkg::PROD_W'(yr_ff)) begin
                  leap_in = (q_ff[1:0] == 2'd0);
               end else begin
                  leap_in = (yr_ff[1:0] == 2'd0);
               end
            end
            gdas_pkg::OP_CLAMPD: begin
               if (dy_ff == '0) begin
                  dy_in = gdas_pkg::DAY_W'(1);
               end else if (dy_ff > len) begin
                  dy_in = len;
               end
            end
            gdas_pkg::OP_SER_Q: begin
               ser_in = gdas_pkg::SERIAL_W'(p >> 2) - gdas_pkg::SERIAL_W'(q_ff)
                        + gdas_pkg::SERIAL_W'(q_ff >> 2);
            end
            gdas_pkg::OP_SER_ADDP: ser_in = ser_ff + prod_ff[gdas_pkg::SERIAL_W-1:0];
            gdas_pkg::OP_SER_ADDM: begin
               ser_in = ser_ff + gdas_pkg::SERIAL_W'(days_before(mo_ff))
                        + gdas_pkg::SERIAL_W'(leap_ff && mo_ff > 4'd2)
                        + gdas_pkg::SERIAL_W'(dy_ff) - gdas_pkg::SERIAL_W'(1);
            end
            gdas_pkg::OP_SET_ADV: adv_in = 1'b1;
            gdas_pkg::OP_ADV_STEP: begin
               if (step_over) begin
                  off_in = off_ff - gdas_pkg::OFF_W'(left) - gdas_pkg::OFF_W'(1);
                  dy_in  = gdas_pkg::DAY_W'(1);
                  if (mo_ff == 4'd12) begin
                     mo_in = 4'd1;
                     yr_in = yr_ff + gdas_pkg::YREG_W'(1);
                  end else begin
                     mo_in = mo_ff + 4'd1;
                  end
               end else begin
                  dy_in  = dy_ff + off_ff[gdas_pkg::DAY_W-1:0];
                  off_in = '0;
               end
            end
            gdas_pkg::OP_CHK_OV: ov_in = stat.y_over;
            gdas_pkg::OP_FINISH: fire_finish = 1'b1;
            default: ;
         endcase
      end
   end

   // result word, saturated when the year ran past the top
   always_comb begin
      rsp_valid_in  = fire_finish || (rsp_valid_ff && !rsp_chan.ready);
      rsp_serial_in = rsp_serial_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_ov_in     = rsp_ov_ff;
      if (fire_finish) begin
         rsp_serial_in = ser_ff;
         rsp_ov_in     = ov_ff;
         if (ov_ff) begin
            rsp_year_in  = gdas_pkg::YEAR_W'(gdas_pkg::MAX_YEAR);
            rsp_month_in = 4'd12;
            rsp_day_in   = 5'd31;
         end else begin
            rsp_year_in  = yr_ff[gdas_pkg::YEAR_W-1:0];
            rsp_month_in = mo_ff;
            rsp_day_in   = dy_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_ff       <= 1'b0;
         ov_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         adv_ff       <= adv_in;
         ov_ff        <= ov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      yr_ff         <= yr_in;
      mo_ff         <= mo_in;
      dy_ff         <= dy_in;
      off_ff        <= off_in;
      ser_ff        <= ser_in;
      q_ff          <= q_in;
      prod_ff       <= prod_in;
      leap_ff       <= leap_in;
      rsp_serial_ff <= rsp_serial_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_ov_ff     <= rsp_ov_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.serial_day    = rsp_serial_ff;
   assign rsp_chan.new_year      = rsp_year_ff;
   assign rsp_chan.new_month     = rsp_month_ff;
   assign rsp_chan.new_day       = rsp_day_ff;
   assign rsp_chan.year_overflow = rsp_ov_ff;

   a_day_in_month: assert property (@(posedge clock) disable iff (reset)
      adv_ff |-> (dy_ff != '0 && dy_ff <= len))
      else $error("day left its month during advance");

   a_ov_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ov_ff) |->
         (rsp_year_ff == gdas_pkg::YEAR_W'(gdas_pkg::MAX_YEAR) &&
          rsp_month_ff == 4'd12 && rsp_day_ff == 5'd31))
      else $error("overflowed result not saturated");

   a_result_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_month_ff != '0 && rsp_month_ff <= 4'd12 && rsp_day_ff != '0))
      else $error("result month or day out of range");

endmodule

`default_nettype wire

@@ hdl/gregorian_date_advance_and_serial_unit.sv @@
// Gregorian date unit: serial day number and forward date advance.
// req_chan carries one word: year, month, day_of_month, day_offset. Out-of-range
// inputs are clamped to the nearest valid date. rsp_chan returns one word per
// request: serial_day (days since 0001-01-01), the advanced date and
// year_overflow, with the date saturated to 9999-12-31 when it runs off the end.
// Both channels use valid/ready; a word moves when both are high.
// A small microcoded sequencer drives one datapath with a single shared multiplier.
// The advance walks forward one month boundary at a time and reruns the leap-year
// recompute at each year boundary. One request is worked at a time; req ready is
// high only while the sequencer sits at its idle step.
// The result sits in an output register: a new request is accepted while it
// waits, but a finished word stalls the sequencer until the old one is taken.
// Synchronous reset returns the sequencer to idle and drops rsp valid.
`default_nettype none

module gregorian_date_advance_and_serial_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   gdas_req_if.sink     req_chan,
   gdas_rsp_if.source   rsp_chan
);

   gdas_pkg::seq_ctl_type ctl;
   gdas_pkg::dp_stat_type stat;
   logic                  req_ready;

   gdas_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .stat      (stat),
      .ctl       (ctl),
      .req_ready (req_ready)
   );

   gdas_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .stat     (stat),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   assign req_chan.ready = req_ready;

endmodule

`default_nettype wire

@@ bench/gdas_date_checker.sv @@
`default_nettype none

module gdas_date_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   gdas_req_if               req_mon,
   gdas_rsp_if               rsp_mon,
   output int unsigned       fail_count,
   output int unsigned       awaited
);

   typedef struct packed {
      logic [gdas_pkg::SERIAL_W-1:0] serial_day;
      logic [gdas_pkg::YEAR_W-1:0]   new_year;
      logic [gdas_pkg::MONTH_W-1:0]  new_month;
      logic [gdas_pkg::DAY_W-1:0]    new_day;
      logic                          year_overflow;
   } date_result_type;

   date_result_type awaited_dates[$];
   int unsigned     errs = 0;

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
   endfunction

   function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
      case (m)
         2: begin
            return leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            return 30;
         end
         default: begin
            return 31;
         end
      endcase
   endfunction

   // serial day of the clamped date, then walk forward a month at a time
   function automatic date_result_type advance_date(int unsigned y, int unsigned m,
                                                    int unsigned d, int unsigned off);
      date_result_type r;
      int unsigned     p;
      int unsigned     serial;
      int unsigned     left;
      bit              over;
      over = 1'b0;
      if (y < 1) y = 1;
      if (y > gdas_pkg::MAX_YEAR) y = gdas_pkg::MAX_YEAR;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > days_in_month(y, m)) d = days_in_month(y, m);

      p = y - 1;
      serial = p * 365 + p / 4 - p / 100 + p / 400;
      for (int k = 1; k < m; k++) serial += days_in_month(y, k);
      serial += d - 1;

      while (off > 0 && !over) begin
         left = days_in_month(y, m) - d;
         if (off > left) begin
            off -= left + 1;
            d = 1;
            if (m == 12) begin
               m = 1;
               y++;
               if (y > gdas_pkg::MAX_YEAR) over = 1'b1;
            end else begin
               m++;
            end
         end else begin
            d += off;
            off = 0;
         end
      end
      if (over) begin
         y = gdas_pkg::MAX_YEAR;
         m = 12;
         d = 31;
      end

      r.serial_day    = gdas_pkg::SERIAL_W'(serial);
      r.new_year      = gdas_pkg::YEAR_W'(y);
      r.new_month     = gdas_pkg::MONTH_W'(m);
      r.new_day       = gdas_pkg::DAY_W'(d);
      r.year_overflow = over;
      return r;
   endfunction

   task automatic check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      date_result_type want;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_dates.size() == 0) begin
               $display("%0t: result word with none expected, got %0d %0d-%0d-%0d ov=%0d",
                        $time, rsp_mon.serial_day, rsp_mon.new_year, rsp_mon.new_month,
                        rsp_mon.new_day, rsp_mon.year_overflow);
               errs++;
            end else begin
               want = awaited_dates.pop_front();
               check_field("serial_day", 32'(want.serial_day), 32'(rsp_mon.serial_day));
               check_field("new_year", 32'(want.new_year), 32'(rsp_mon.new_year));
               check_field("new_month", 32'(want.new_month), 32'(rsp_mon.new_month));
               check_field("new_day", 32'(want.new_day), 32'(rsp_mon.new_day));
               check_field("year_overflow", 32'(want.year_overflow),
                           32'(rsp_mon.year_overflow));
            end
         end
         if (req_mon.valid && req_mon.ready)
            awaited_dates.push_back(advance_date(32'(req_mon.year), 32'(req_mon.month),
                                                 32'(req_mon.day_of_month),
                                                 32'(req_mon.day_offset)));
      end
      awaited    <= awaited_dates.size();
      fail_count <= errs;
   end

endmodule

`default_nettype wire

@@ bench/gregorian_date_advance_and_serial_unit_test.sv @@
`default_nettype none

module gregorian_date_advance_and_serial_unit_test;

   logic        clock;
   logic        reset = 1'b1;
   int unsigned fail_count;
   int unsigned awaited;

   gdas_req_if req_chan();
   gdas_rsp_if rsp_chan();

   gregorian_date_advance_and_serial_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   gdas_date_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .awaited    (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // sender pacing: stretches of back-to-back words alternate with random gaps
   bit          send_calm = 1'b0;
   int unsigned send_run  = 0;

   task automatic send_date(logic [gdas_pkg::YEAR_W-1:0] y,
                            logic [gdas_pkg::MONTH_W-1:0] m,
                            logic [gdas_pkg::DAY_W-1:0] d,
                            logic [gdas_pkg::OFF_W-1:0] off);
      int unsigned gap;
      if (send_run == 0) begin
         send_calm = ($urandom_range(0, 2) == 0);
         send_run  = $urandom_range(10, 40);
      end
      send_run--;
      gap = send_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.year         <= y;
      req_chan.month        <= m;
      req_chan.day_of_month <= d;
      req_chan.day_offset   <= off;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold off until every word sent so far has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited != 0) @(posedge clock);
   endtask

   initial begin
      logic [gdas_pkg::YEAR_W-1:0]  y;
      logic [gdas_pkg::MONTH_W-1:0] m;
      logic [gdas_pkg::DAY_W-1:0]   d;
      logic [gdas_pkg::OFF_W-1:0]   off;
      int unsigned                  pick;
      int unsigned                  span;

      req_chan.valid        <= 1'b0;
      req_chan.year         <= '0;
      req_chan.month        <= '0;
      req_chan.day_of_month <= '0;
      req_chan.day_offset   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, clamping, leap rule and the end of the calendar
      send_date(14'd1, 4'd1, 5'd1, 16'd0);
      send_date(14'd9999, 4'd12, 5'd31, 16'd0);
      send_date(14'd9999, 4'd12, 5'd31, 16'd1);
      send_date(14'd9999, 4'd12, 5'd31, 16'hFFFF);
      send_date(14'd1, 4'd1, 5'd1, 16'hFFFF);
      send_date(14'd0, 4'd0, 5'd0, 16'd0);
      send_date(14'd0, 4'd1, 5'd1, 16'd10);
      send_date(14'h3FFF, 4'd6, 5'd15, 16'd100);
      send_date(14'h3FFF, 4'hF, 5'h1F, 16'hFFFF);
      send_date(14'd2000, 4'd0, 5'd5, 16'd0);
      send_date(14'd2001, 4'd15, 5'd31, 16'd1);
      send_date(14'd2004, 4'd3, 5'd0, 16'd0);
      send_date(14'd2000, 4'd2, 5'd31, 16'd1);
      send_date(14'd1900, 4'd2, 5'd31, 16'd0);
      send_date(14'd2023, 4'd4, 5'd31, 16'd0);
      send_date(14'd2000, 4'd2, 5'd28, 16'd1);
      send_date(14'd1900, 4'd2, 5'd28, 16'd1);
      send_date(14'd2024, 4'd2, 5'd28, 16'd1);
      send_date(14'd2023, 4'd2, 5'd28, 16'd1);
      send_date(14'd1999, 4'd12, 5'd31, 16'd1);
      send_date(14'd2000, 4'd1, 5'd31, 16'd29);
      send_date(14'd9998, 4'd12, 5'd31, 16'd365);
      send_date(14'd9998, 4'd12, 5'd31, 16'd366);
      send_date(14'd9999, 4'd1, 5'd1, 16'd364);
      send_date(14'd9999, 4'd1, 5'd1, 16'd365);
      drain_results();

      for (int n = 0; n < 1000; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            // raw fields, out-of-range values included
            y = gdas_pkg::YEAR_W'($urandom_range(0, 16383));
            m = gdas_pkg::MONTH_W'($urandom_range(0, 15));
            d = gdas_pkg::DAY_W'($urandom_range(0, 31));
         end else begin
            y = gdas_pkg::YEAR_W'((pick < 18) ? $urandom_range(9800, 9999)
                                              : $urandom_range(1, 9999));
            m = gdas_pkg::MONTH_W'($urandom_range(1, 12));
            d = gdas_pkg::DAY_W'(($urandom_range(0, 3) == 0) ? $urandom_range(25, 31)
                                                             : $urandom_range(1, 28));
         end
         // mostly short advances; long ones are slow on the block
         span = $urandom_range(0, 99);
         if (pick >= 12 && pick < 18)
            off = gdas_pkg::OFF_W'($urandom_range(0, 65535));
         else if (span < 65)
            off = gdas_pkg::OFF_W'($urandom_range(0, 63));
         else if (span < 88)
            off = gdas_pkg::OFF_W'($urandom_range(0, 2047));
         else if (span < 96)
            off = gdas_pkg::OFF_W'($urandom_range(0, 20000));
         else
            off = gdas_pkg::OFF_W'($urandom_range(0, 65535));
         send_date(y, m, d, off);
         if (n == 300 || n == 700) drain_results();
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // result side back-pressure
   initial begin
      bit          calm;
      int unsigned run_left;
      int unsigned stall;
      calm     = 1'b0;
      run_left = 0;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (run_left == 0) begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(10, 40);
         end
         run_left--;
         stall = calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   initial begin
      #400_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

@@ gregorian_date_advance_and_serial_unit.f @@
hdl/gdas_pkg.sv
hdl/gdas_if.sv
hdl/gdas_sequencer.sv
hdl/gdas_datapath.sv
hdl/gregorian_date_advance_and_serial_unit.sv
bench/gdas_date_checker.sv
bench/gregorian_date_advance_and_serial_unit_test.sv
